[rtl/iadr_pkg.sv]
// Package for the indexed array insert/delete/rotate unit.
// Holds widths, request and status codes and the sequencer state type.
// No dependencies.
package iadr_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 3;
	localparam int ST_W      = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ = 3'd0,
		REQ_ROTL = 3'd1,
		REQ_ROTR = 3'd2,
		REQ_INS  = 3'd3,
		REQ_DEL  = 3'd4
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADIDX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HOLD,
		S_MOVE,
		S_PUT,
		S_DONE
	} state_t;

endpackage

[rtl/iadr_in_if.sv]
// Request channel of the indexed array unit: valid/ready and request payload.
// Depends on iadr_pkg.
interface iadr_in_if #(
	parameter int PW = 7
) ();
	logic                               valid;
	logic                               ready;
	logic [iadr_pkg::REQ_W-1:0]         req_type;
	logic [PW-1:0]                      position;
	logic signed [iadr_pkg::DATA_W-1:0] new_value;

	modport source (output valid, output req_type, output position, output new_value,
		input ready);
	modport sink (input valid, input req_type, input position, input new_value,
		output ready);
endinterface

[rtl/iadr_out_if.sv]
// Response channel of the indexed array unit: valid/ready and result payload.
// Depends on iadr_pkg.
interface iadr_out_if #(
	parameter int CW = 7
) ();
	logic                               valid;
	logic                               ready;
	logic [iadr_pkg::ST_W-1:0]          status;
	logic signed [iadr_pkg::DATA_W-1:0] read_value;
	logic [CW-1:0]                      live_count;

	modport source (output valid, output status, output read_value, output live_count,
		input ready);
	modport sink (input valid, input status, input read_value, input live_count,
		output ready);
endinterface

[rtl/iadr_store.sv]
// Element store: one write port and one read port, registered read data.
// Depends on iadr_pkg.
module iadr_store #(
	parameter int DEPTH  = iadr_pkg::DEPTH_DEF,
	parameter int DATA_W = iadr_pkg::DATA_W,
	localparam int IW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              re,
	input  logic [IW-1:0]     raddr,
	input  logic              we,
	input  logic [IW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

[rtl/indexed_array_insert_delete_rotate_unit.sv]
// Indexed array unit: read, rotate, insert and delete on a packed word array.
// Steps: a read goes through S_HOLD to S_DONE, errors straight to S_DONE; rotates read
// an end word in S_HOLD, shift in S_MOVE, write it back in S_PUT; insert/delete shift.
// One word moves per cycle through the store; the next request is taken at the
// edge where the result can first leave, and a held response stalls the unit.
// Reset clears the live count and the sequencer; store contents stay undefined.
module indexed_array_insert_delete_rotate_unit #(
	parameter int DEPTH = iadr_pkg::DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int IW   = $clog2(DEPTH)
) (
	input logic clk,
	input logic arst_n,
	iadr_in_if.sink    req,
	iadr_out_if.source rsp
);
	localparam int DW = iadr_pkg::DATA_W;

	iadr_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [IW-1:0]     k_q, k_d;
	logic [CW-1:0]     left_q, left_d;
	logic              up_q, up_d;
	logic              put_q, put_d;
	logic [IW-1:0]     put_addr_q, put_addr_d;
	logic [DW-1:0]     hold_q, hold_d;
	logic              rd_mode_q, rd_mode_d;
	iadr_pkg::status_t status_q, status_d;
	logic [DW-1:0]     value_q, value_d;
	logic              out_valid_q, out_valid_d;
	iadr_pkg::status_t out_status_q;
	logic [DW-1:0]     out_value_q;
	logic [CW-1:0]     out_count_q;
	logic              out_load;
	logic              wpend_s1, wpend_d;
	logic [IW-1:0]     waddr_s1;
	logic              re;
	logic [IW-1:0]     raddr;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [DW-1:0]     wdata;
	logic [DW-1:0]     rdata;
	logic [CW-1:0]     n_m1;

	assign n_m1 = count_q - CW'(1);

	iadr_store #(
		.DEPTH  (DEPTH),
		.DATA_W (DW)
	) u_store (
		.clk   (clk),
		.re    (re),
		.raddr (raddr),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.rdata (rdata)
	);

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		k_d        = k_q;
		left_d     = left_q;
		up_d       = up_q;
		put_d      = put_q;
		put_addr_d = put_addr_q;
		hold_d     = hold_q;
		rd_mode_d  = rd_mode_q;
		status_d   = status_q;
		value_d    = value_q;
		out_load   = 1'b0;
		wpend_d    = 1'b0;
		re         = 1'b0;
		raddr      = '0;
		unique case (state_q)
			iadr_pkg::S_IDLE: begin
				if (req.valid) begin
					status_d  = iadr_pkg::ST_OK;
					value_d   = '0;
					rd_mode_d = 1'b0;
					put_d     = 1'b0;
					state_d   = iadr_pkg::S_DONE;
					unique case (iadr_pkg::req_t'(req.req_type))
						iadr_pkg::REQ_READ: begin
							if (count_q == '0) begin
								status_d = iadr_pkg::ST_EMPTY;
							end else if (req.position >= count_q) begin
								status_d = iadr_pkg::ST_BADIDX;
							end else begin
								re        = 1'b1;
								raddr     = req.position[IW-1:0];
								rd_mode_d = 1'b1;
								state_d   = iadr_pkg::S_HOLD;
							end
						end
						iadr_pkg::REQ_ROTL: begin
							if (count_q == '0) begin
								status_d = iadr_pkg::ST_EMPTY;
							end else begin
								re         = 1'b1;
								raddr      = '0;
								left_d     = n_m1;
								k_d        = '0;
								up_d       = 1'b0;
								put_d      = 1'b1;
								put_addr_d = n_m1[IW-1:0];
								state_d    = iadr_pkg::S_HOLD;
							end
						end
						iadr_pkg::REQ_ROTR: begin
							if (count_q == '0) begin
								status_d = iadr_pkg::ST_EMPTY;
							end else begin
								re         = 1'b1;
								raddr      = n_m1[IW-1:0];
								left_d     = n_m1;
								k_d        = n_m1[IW-1:0];
								up_d       = 1'b1;
								put_d      = 1'b1;
								put_addr_d = '0;
								state_d    = iadr_pkg::S_HOLD;
							end
						end
						iadr_pkg::REQ_INS: begin
							if (count_q == CW'(DEPTH)) begin
								status_d = iadr_pkg::ST_FULL;
							end else if (req.position > count_q) begin
								status_d = iadr_pkg::ST_BADIDX;
							end else begin
								hold_d     = req.new_value;
								left_d     = count_q - req.position;
								k_d        = count_q[IW-1:0];
								up_d       = 1'b1;
								put_d      = 1'b1;
								put_addr_d = req.position[IW-1:0];
								count_d    = count_q + CW'(1);
								state_d    = iadr_pkg::S_MOVE;
							end
						end
						iadr_pkg::REQ_DEL: begin
							if (count_q == '0) begin
								status_d = iadr_pkg::ST_EMPTY;
							end else if (req.position >= count_q) begin
								status_d = iadr_pkg::ST_BADIDX;
							end else begin
								left_d  = n_m1 - req.position;
								k_d     = req.position[IW-1:0];
								up_d    = 1'b0;
								count_d = n_m1;
								state_d = iadr_pkg::S_MOVE;
							end
						end
						default: begin
							status_d = iadr_pkg::ST_BADIDX;
						end
					endcase
				end
			end
			iadr_pkg::S_HOLD: begin
				if (rd_mode_q) begin
					value_d = rdata;
					state_d = iadr_pkg::S_DONE;
				end else begin
					hold_d  = rdata;
					state_d = iadr_pkg::S_MOVE;
				end
			end
			iadr_pkg::S_MOVE: begin
				if (left_q != '0) begin
					re      = 1'b1;
					raddr   = up_q ? (k_q - IW'(1)) : (k_q + IW'(1));
					wpend_d = 1'b1;
					k_d     = up_q ? (k_q - IW'(1)) : (k_q + IW'(1));
					left_d  = left_q - CW'(1);
				end else begin
					state_d = iadr_pkg::S_PUT;
				end
			end
			iadr_pkg::S_PUT: begin
				state_d = iadr_pkg::S_DONE;
			end
			iadr_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = iadr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = iadr_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = waddr_s1;
		wdata = rdata;
		if (wpend_s1) begin
			we = 1'b1;
		end else if (state_q == iadr_pkg::S_PUT && put_q) begin
			we    = 1'b1;
			waddr = put_addr_q;
			wdata = hold_q;
		end
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (rsp.ready) begin
			out_valid_d = 1'b0;
		end
		if (out_load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= iadr_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			wpend_s1    <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
			wpend_s1    <= wpend_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q        <= k_d;
		left_q     <= left_d;
		up_q       <= up_d;
		put_q      <= put_d;
		put_addr_q <= put_addr_d;
		hold_q     <= hold_d;
		rd_mode_q  <= rd_mode_d;
		status_q   <= status_d;
		value_q    <= value_d;
		waddr_s1   <= k_q;
		if (out_load) begin
			out_status_q <= status_q;
			out_value_q  <= value_q;
			out_count_q  <= count_q;
		end
	end

	assign req.ready      = (state_q == iadr_pkg::S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.read_value = out_value_q;
	assign rsp.live_count = out_count_q;
endmodule

[rtl/iadr_chk.sv]
// Port checker for the indexed array unit, bound to the top level.
// Depends on iadr_pkg and indexed_array_insert_delete_rotate_unit.
module iadr_chk #(
	parameter int DEPTH = iadr_pkg::DEPTH_DEF,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [iadr_pkg::ST_W-1:0]  status,
	input logic [iadr_pkg::DATA_W-1:0] read_value,
	input logic [CW-1:0]              live_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)
			&& $stable(read_value) && $stable(live_count)))
		else $error("response beat dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while previous one in flight");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == iadr_pkg::ST_FULL) |-> (live_count == CW'(DEPTH)))
		else $error("overflow reported below full count");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == iadr_pkg::ST_EMPTY) |-> (live_count == '0))
		else $error("empty reported with live elements");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != iadr_pkg::ST_OK) |-> (read_value == '0))
		else $error("non-zero value on failed request");
endmodule

bind indexed_array_insert_delete_rotate_unit iadr_chk #(
	.DEPTH (DEPTH)
) u_iadr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.status     (rsp.status),
	.read_value (rsp.read_value),
	.live_count (rsp.live_count)
);

[dv/iadr_checker.sv]
// Scoreboard for the indexed array unit: watches request and response beats,
// keeps its own copy of the word array and live count, and checks each result.
// Depends on iadr_pkg.
module iadr_checker #(
	parameter int DEPTH = iadr_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	input  logic                               req_ready,
	input  logic [iadr_pkg::REQ_W-1:0]         req_type,
	input  logic [CW-1:0]                      position,
	input  logic signed [iadr_pkg::DATA_W-1:0] new_value,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic [iadr_pkg::ST_W-1:0]          status,
	input  logic signed [iadr_pkg::DATA_W-1:0] read_value,
	input  logic [CW-1:0]                      live_count,
	output int                                 fail_count,
	output int                                 pending,
	output int                                 checked,
	output int                                 peak_fill,
	output int                                 overflow_hits,
	output logic [CW-1:0]                      fill
);

	typedef struct packed {
		iadr_pkg::status_t                  status;
		logic signed [iadr_pkg::DATA_W-1:0] value;
		logic [CW-1:0]                      count;
	} array_reply_t;

	logic signed [iadr_pkg::DATA_W-1:0] word_store [DEPTH];
	array_reply_t                       reply_q [$];

	function automatic array_reply_t apply_request(input logic [iadr_pkg::REQ_W-1:0] kind,
		input logic [CW-1:0] pos, input logic signed [iadr_pkg::DATA_W-1:0] word);
		array_reply_t                       r;
		logic signed [iadr_pkg::DATA_W-1:0] keep;
		int                                 k;
		int                                 n;
		r.status = iadr_pkg::ST_OK;
		r.value  = '0;
		n = int'(fill);
		case (kind)
			iadr_pkg::REQ_READ: begin
				if (n == 0)
					r.status = iadr_pkg::ST_EMPTY;
				else if (int'(pos) >= n)
					r.status = iadr_pkg::ST_BADIDX;
				else
					r.value = word_store[int'(pos)];
			end
			iadr_pkg::REQ_ROTL: begin
				if (n == 0) begin
					r.status = iadr_pkg::ST_EMPTY;
				end else begin
					keep = word_store[0];
					for (k = 0; k < n - 1; k++)
						word_store[k] = word_store[k + 1];
					word_store[n - 1] = keep;
				end
			end
			iadr_pkg::REQ_ROTR: begin
				if (n == 0) begin
					r.status = iadr_pkg::ST_EMPTY;
				end else begin
					keep = word_store[n - 1];
					for (k = n - 1; k > 0; k--)
						word_store[k] = word_store[k - 1];
					word_store[0] = keep;
				end
			end
			iadr_pkg::REQ_INS: begin
				if (n >= DEPTH) begin
					r.status = iadr_pkg::ST_FULL;
				end else if (int'(pos) > n) begin
					r.status = iadr_pkg::ST_BADIDX;
				end else begin
					for (k = n; k > int'(pos); k--)
						word_store[k] = word_store[k - 1];
					word_store[int'(pos)] = word;
					fill = CW'(n + 1);
				end
			end
			iadr_pkg::REQ_DEL: begin
				if (n == 0) begin
					r.status = iadr_pkg::ST_EMPTY;
				end else if (int'(pos) >= n) begin
					r.status = iadr_pkg::ST_BADIDX;
				end else begin
					for (k = int'(pos); k < n - 1; k++)
						word_store[k] = word_store[k + 1];
					fill = CW'(n - 1);
				end
			end
			default: r.status = iadr_pkg::ST_BADIDX;
		endcase
		r.count = fill;
		return r;
	endfunction

	always @(posedge clk) begin
		array_reply_t want;
		if (!arst_n) begin
			reply_q.delete();
			fill          = '0;
			fail_count    = 0;
			pending       = 0;
			checked       = 0;
			peak_fill     = 0;
			overflow_hits = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (reply_q.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					checked++;
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (read_value !== want.value) begin
						$error("read_value: expected %0d, actual %0d", want.value, read_value);
						fail_count++;
					end
					if (live_count !== want.count) begin
						$error("live_count: expected %0d, actual %0d", want.count, live_count);
						fail_count++;
					end
				end
			end
			if (req_valid && req_ready) begin
				want = apply_request(req_type, position, new_value);
				reply_q.push_back(want);
				if (want.status == iadr_pkg::ST_FULL)
					overflow_hits++;
				if (int'(fill) > peak_fill)
					peak_fill = int'(fill);
			end
			pending = reply_q.size();
		end
	end

endmodule

[dv/tb_indexed_array_insert_delete_rotate_unit.sv]
// Testbench top for the indexed array unit: clock, reset, request stimulus and
// response back-pressure; checking is done by iadr_checker beside the block.
// Depends on iadr_pkg, iadr_in_if, iadr_out_if and iadr_checker.
module tb_indexed_array_insert_delete_rotate_unit;

	localparam int DEPTH       = iadr_pkg::DEPTH_DEF;
	localparam int CW          = $clog2(DEPTH + 1);
	localparam int HOLD_CYCLES = 400;

	typedef logic [iadr_pkg::REQ_W-1:0]         kind_t;
	typedef logic signed [iadr_pkg::DATA_W-1:0] word_t;

	logic clk = 1'b0;
	logic arst_n;
	bit   no_idle;
	bit   hold_rsp;
	int   sent;

	int            fail_count;
	int            pending;
	int            checked;
	int            peak_fill;
	int            overflow_hits;
	logic [CW-1:0] fill;

	iadr_in_if  #(.PW(CW)) req_ch ();
	iadr_out_if #(.CW(CW)) rsp_ch ();

	indexed_array_insert_delete_rotate_unit #(.DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	iadr_checker #(.DEPTH(DEPTH), .CW(CW)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_ch.valid),
		.req_ready     (req_ch.ready),
		.req_type      (req_ch.req_type),
		.position      (req_ch.position),
		.new_value     (req_ch.new_value),
		.rsp_valid     (rsp_ch.valid),
		.rsp_ready     (rsp_ch.ready),
		.status        (rsp_ch.status),
		.read_value    (rsp_ch.read_value),
		.live_count    (rsp_ch.live_count),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.peak_fill     (peak_fill),
		.overflow_hits (overflow_hits),
		.fill          (fill)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'sh7fff_ffff;
			1:       return 32'sh8000_0000;
			2:       return -32'sd1;
			3:       return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(input kind_t kind, input logic [CW-1:0] pos,
		input word_t word);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid     = 1'b1;
		req_ch.req_type  = kind;
		req_ch.position  = pos;
		req_ch.new_value = word;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic random_request(input int ins_pct, input int del_pct);
		int            r;
		kind_t         kind;
		logic [CW-1:0] pos;
		r = $urandom_range(0, 99);
		if (r < ins_pct) begin
			kind = iadr_pkg::REQ_INS;
		end else if (r < ins_pct + del_pct) begin
			kind = iadr_pkg::REQ_DEL;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 55)
				kind = iadr_pkg::REQ_READ;
			else if (r < 75)
				kind = iadr_pkg::REQ_ROTL;
			else if (r < 96)
				kind = iadr_pkg::REQ_ROTR;
			else
				kind = kind_t'(iadr_pkg::REQ_DEL) + kind_t'($urandom_range(1, 3));
		end
		if ($urandom_range(0, 9) < 8)
			pos = CW'($urandom_range(0, int'(fill)));
		else
			pos = CW'($urandom_range(0, DEPTH));
		send_request(kind, pos, pick_word());
	endtask

	task automatic drain_results();
		req_ch.valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	initial begin
		int  stall;
		bit  held;
		stall = 0;
		held  = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp && !held) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end else if (!hold_rsp) begin
				held = 1'b0;
			end
			if (stall == 0 && $urandom_range(0, 3) == 0)
				stall = pick_gap();
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				stall--;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	initial begin
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.req_type  = '0;
		req_ch.position  = '0;
		req_ch.new_value = '0;
		no_idle          = 1'b0;
		hold_rsp         = 1'b0;
		sent             = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty array, unknown kinds, insert past the end
		send_request(iadr_pkg::REQ_READ, '0, '0);
		send_request(iadr_pkg::REQ_ROTL, '0, '0);
		send_request(iadr_pkg::REQ_ROTR, '0, '0);
		send_request(iadr_pkg::REQ_DEL, '0, '0);
		send_request(kind_t'(iadr_pkg::REQ_DEL) + kind_t'(1), '0, '0);
		send_request(kind_t'(iadr_pkg::REQ_DEL) + kind_t'(2), CW'(DEPTH), -32'sd1);
		send_request(kind_t'(iadr_pkg::REQ_DEL) + kind_t'(3), '1, 32'sh8000_0000);
		send_request(iadr_pkg::REQ_INS, CW'(1), 32'sd5);
		// build up, append at the end, read back, rotate, delete
		send_request(iadr_pkg::REQ_INS, '0, 32'sh7fff_ffff);
		send_request(iadr_pkg::REQ_INS, CW'(1), 32'sh8000_0000);
		send_request(iadr_pkg::REQ_INS, '0, -32'sd1);
		send_request(iadr_pkg::REQ_INS, CW'(1), '0);
		send_request(iadr_pkg::REQ_READ, '0, '0);
		send_request(iadr_pkg::REQ_READ, CW'(1), '0);
		send_request(iadr_pkg::REQ_READ, CW'(2), '0);
		send_request(iadr_pkg::REQ_READ, CW'(3), '0);
		send_request(iadr_pkg::REQ_READ, CW'(4), '0);
		send_request(iadr_pkg::REQ_READ, CW'(DEPTH), '0);
		send_request(iadr_pkg::REQ_ROTL, CW'(DEPTH), '0);
		send_request(iadr_pkg::REQ_ROTR, '0, '0);
		send_request(iadr_pkg::REQ_DEL, CW'(4), '0);
		send_request(iadr_pkg::REQ_DEL, CW'(DEPTH), '0);
		send_request(iadr_pkg::REQ_DEL, '0, '0);
		send_request(iadr_pkg::REQ_DEL, CW'(2), '0);
		drain_results();

		repeat (400) random_request(30, 15);
		drain_results();
		// fill up to overflow
		repeat (300) random_request(85, 5);
		drain_results();
		// drain to empty
		repeat (250) random_request(5, 85);
		drain_results();
		no_idle = 1'b1;
		repeat (200) random_request(35, 30);
		drain_results();
		no_idle = 1'b0;
		// hold the response side while requests keep coming
		hold_rsp = 1'b1;
		repeat (60) random_request(40, 20);
		drain_results();
		hold_rsp = 1'b0;
		repeat (316) random_request(35, 25);
		drain_results();

		repeat (4 * DEPTH) @(posedge clk);
		$display("Sent %0d requests, checked %0d results; peak fill %0d of %0d,",
			sent, checked, peak_fill, DEPTH);
		$display("%0d overflow replies; covered empty, bad-index and unknown requests,",
			overflow_hits);
		$display("long response hold-off and back-to-back beats.");
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#25_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
